// File: rtl/ssm_pkg.sv
// ---------------------------------------------------------------------------
// ssm_pkg: shared types and constants for the sorted sequence merge block
// Holds the store depth, index widths, command codes and beat structs.
// ---------------------------------------------------------------------------
package ssm_pkg;

	// Number of elements each store can hold.
	localparam int DEPTH = 32;
	// Bits needed to address one store entry.
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Bits needed to count from zero up to DEPTH inclusive.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] FUNC_PUSH_A = 2'd0;
	localparam logic [1:0] FUNC_PUSH_B = 2'd1;
	localparam logic [1:0] FUNC_MERGE  = 2'd2;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] value;
	} ssm_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     from_second;
		logic                     last;
	} ssm_out_t;

	// Decision of the head comparator for one merge step.
	typedef struct packed {
		logic                     take_second;
		logic signed [DATA_W-1:0] value;
	} ssm_pick_t;

endpackage

// File: rtl/ssm_ram.sv
// ---------------------------------------------------------------------------
// ssm_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/ssm_cmp.sv
// ---------------------------------------------------------------------------
// ssm_cmp: head comparator of the merge
// Picks the smaller head, favoring the first sequence on a tie.
// ---------------------------------------------------------------------------
module ssm_cmp (
	input  logic                             a_done,
	input  logic                             b_done,
	input  logic signed [ssm_pkg::DATA_W-1:0] head_a,
	input  logic signed [ssm_pkg::DATA_W-1:0] head_b,
	output ssm_pkg::ssm_pick_t               pick
);
	import ssm_pkg::*;

	// An exhausted first sequence forces the second; otherwise the second
	// wins only when strictly smaller, which keeps the merge stable.
	always_comb begin
		pick.take_second = a_done | (~b_done & (head_a > head_b));
		pick.value       = pick.take_second ? head_b : head_a;
	end

endmodule

// File: rtl/ssm_ctl.sv
// ---------------------------------------------------------------------------
// ssm_ctl: load and merge sequencer
// Tracks the fill counts, drives the store ports and steps the merge.
// ---------------------------------------------------------------------------
module ssm_ctl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  ssm_pkg::ssm_in_t                  cmd,
	output logic                              busy,
	output logic                              we_a,
	output logic                              we_b,
	output logic [ssm_pkg::IDX_W-1:0]         waddr_a,
	output logic [ssm_pkg::IDX_W-1:0]         waddr_b,
	output logic [ssm_pkg::DATA_W-1:0]        wdata,
	output logic [ssm_pkg::IDX_W-1:0]         raddr_a,
	output logic [ssm_pkg::IDX_W-1:0]         raddr_b,
	input  logic [ssm_pkg::DATA_W-1:0]        rdata_a,
	input  logic [ssm_pkg::DATA_W-1:0]        rdata_b,
	output logic                              res_valid,
	output ssm_pkg::ssm_out_t                 res
);
	import ssm_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_MERGE = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_a_q;
	logic [CNT_W-1:0] cnt_b_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] i_nxt;
	logic [CNT_W-1:0] j_nxt;
	logic             res_valid_q;
	ssm_out_t         res_q;
	logic             accept;
	logic             merging;
	logic             a_done;
	logic             b_done;
	logic             last_step;
	ssm_pick_t        pick;

	assign busy    = (state_q == ST_MERGE);
	assign merging = busy;
	assign accept  = start & ~busy;

	assign we_a    = accept && (cmd.func == FUNC_PUSH_A) && (cnt_a_q < CNT_W'(DEPTH));
	assign we_b    = accept && (cmd.func == FUNC_PUSH_B) && (cnt_b_q < CNT_W'(DEPTH));
	assign waddr_a = cnt_a_q[IDX_W-1:0];
	assign waddr_b = cnt_b_q[IDX_W-1:0];
	assign wdata   = cmd.value;

	assign a_done = (i_q == cnt_a_q);
	assign b_done = (j_q == cnt_b_q);

	ssm_cmp u_cmp (
		.a_done (a_done),
		.b_done (b_done),
		.head_a (rdata_a),
		.head_b (rdata_b),
		.pick   (pick)
	);

	assign i_nxt = i_q + CNT_W'(merging & ~pick.take_second);
	assign j_nxt = j_q + CNT_W'(merging &  pick.take_second);
	assign last_step = (i_nxt == cnt_a_q) && (j_nxt == cnt_b_q);

	// Look one element ahead so the next head is ready on the next cycle.
	assign raddr_a = merging ? i_nxt[IDX_W-1:0] : '0;
	assign raddr_b = merging ? j_nxt[IDX_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (we_a) begin
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
					if (we_b) begin
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end
					if (accept && (cmd.func == FUNC_MERGE) &&
					    ((cnt_a_q != '0) || (cnt_b_q != '0))) begin
						state_q <= ST_MERGE;
						i_q     <= '0;
						j_q     <= '0;
					end
				end
				ST_MERGE: begin
					res_valid_q <= 1'b1;
					i_q         <= i_nxt;
					j_q         <= j_nxt;
					if (last_step) begin
						state_q <= ST_IDLE;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (merging) begin
			res_q.value_res   <= pick.value;
			res_q.from_second <= pick.take_second;
			res_q.last        <= last_step;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/sorted_sequence_merge_top.sv
// ---------------------------------------------------------------------------
// sorted_sequence_merge_top: stable merge of two ascending sequences
// Loads two stores of signed 32-bit elements and streams their merge.
// ---------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low.
// A push (func 0 or 1) appends cmd.value to the first or second store; a
// push to a full store is dropped. A merge (func 2) raises busy from the
// next cycle and then emits one result beat per clock cycle, one for every
// stored element; busy stays high until the last element is taken. Each
// beat is registered and appears in the cycle after its step, for exactly
// one cycle with res_valid high. The receiver cannot stall them and must
// take every beat as it comes. That rate of one element per cycle is set by
// the single shared head comparator and the registered read port of each
// store, which fetches the next head while the current one is compared.
// The final beat of a merge carries res.last, and both stores are then
// empty again. A merge with both stores empty gives no beat and leaves busy
// low. The stores need no clearing pass after reset: only entries below the
// fill counts are ever used.
// ---------------------------------------------------------------------------
module sorted_sequence_merge_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ssm_pkg::ssm_in_t  cmd,
	output logic              res_valid,
	output ssm_pkg::ssm_out_t res
);
	import ssm_pkg::*;

	logic              we_a;
	logic              we_b;
	logic [IDX_W-1:0]  waddr_a;
	logic [IDX_W-1:0]  waddr_b;
	logic [DATA_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr_a;
	logic [IDX_W-1:0]  raddr_b;
	logic [DATA_W-1:0] rdata_a;
	logic [DATA_W-1:0] rdata_b;

	// The sequencer owns the fill counts, the merge indexes and the output
	// register; the two stores only hold the elements.
	ssm_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.we_a      (we_a),
		.we_b      (we_b),
		.waddr_a   (waddr_a),
		.waddr_b   (waddr_b),
		.wdata     (wdata),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.res_valid (res_valid),
		.res       (res)
	);

	// Store of the first sequence.
	ssm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	// Store of the second sequence.
	ssm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

endmodule

// File: tb/sv/sorted_sequence_merge_top_tb.sv
// ---------------------------------------------------------------------------
// sorted_sequence_merge_top_tb: self-checking bench for the sequence merger
// Loads both stores through the command port, predicts every merged beat and
// checks each result beat against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module sorted_sequence_merge_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssm_pkg::*;

	// The unused command code; the block must ignore it entirely.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Generous ceiling on the run, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	// Quiet cycles granted after the last expected beat has arrived.
	localparam int DRAIN_CYCLES = 8;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	ssm_in_t  cmd = '0;
	logic     res_valid;
	ssm_out_t res;

	sorted_sequence_merge_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res      (res)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow copy of the two stores and their fill counts. It tracks every
	// accepted command beat in order, so it always matches what the block
	// holds at the moment a merge is accepted.
	logic signed [DATA_W-1:0] first_elems [DEPTH];
	logic signed [DATA_W-1:0] second_elems [DEPTH];
	int first_cnt = 0;
	int second_cnt = 0;

	// Merged beats predicted but not yet seen on the result port, oldest first.
	ssm_out_t merged_beats_q [$];

	int error_count = 0;
	int items_sent = 0;
	int sender_idle_pct = 0;
	int cycle_count = 0;

	// Apply one accepted command to the shadow stores. A merge walks both
	// heads: the smaller one goes out, and on a tie the first sequence wins so
	// equal keys keep their load order. When one side runs dry the other side
	// drains in order, and both stores are emptied afterwards.
	task automatic track_command(input ssm_in_t c);
		ssm_out_t beat;
		int       i;
		int       j;
		int       total;
		logic     take_second;
		case (c.func)
			FUNC_PUSH_A: begin
				// A push to a full store is simply dropped.
				if (first_cnt < DEPTH) begin
					first_elems[first_cnt] = c.value;
					first_cnt++;
				end
			end
			FUNC_PUSH_B: begin
				if (second_cnt < DEPTH) begin
					second_elems[second_cnt] = c.value;
					second_cnt++;
				end
			end
			FUNC_MERGE: begin
				i = 0;
				j = 0;
				total = first_cnt + second_cnt;
				for (int k = 0; k < total; k++) begin
					if (i >= first_cnt)
						take_second = 1'b1;
					else if (j >= second_cnt)
						take_second = 1'b0;
					else
						take_second = (first_elems[i] > second_elems[j]);
					if (take_second) begin
						beat.value_res = second_elems[j];
						j++;
					end else begin
						beat.value_res = first_elems[i];
						i++;
					end
					beat.from_second = take_second;
					beat.last = (k == total - 1);
					merged_beats_q.push_back(beat);
				end
				first_cnt = 0;
				second_cnt = 0;
			end
			default: begin
				// Unused code: no beat and no change to either store.
			end
		endcase
	endtask

	// Offer one command beat. The sender may first sit idle for a random
	// number of cycles; then start stays high until an edge sees busy low,
	// which is the edge that takes the beat.
	task automatic send_cmd(input logic [1:0] func, input logic signed [DATA_W-1:0] value);
		ssm_in_t beat;
		beat.func = func;
		beat.value = value;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= beat;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		track_command(beat);
		if (func != FUNC_UNUSED)
			items_sent++;
	endtask

	// Hold off the sender until every predicted beat has come back, then let
	// a few more cycles pass so a stray beat would still be caught.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (merged_beats_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Next element of an ascending sequence. Narrow steps make ties common;
	// wide steps sweep the value range. The sum saturates at the top.
	function automatic logic signed [DATA_W-1:0] next_ascending(
		input logic signed [DATA_W-1:0] prev, input bit narrow);
		longint nxt;
		nxt = longint'(prev) + (narrow ? $urandom_range(2) : $urandom_range(32'h0100_0000));
		if (nxt > longint'(VAL_MAX))
			nxt = longint'(VAL_MAX);
		return nxt[DATA_W-1:0];
	endfunction

	// Load two ascending sequences, interleaving the pushes at random, then
	// merge. About one push in twenty carries a random value instead, which
	// breaks the ordering and exercises unsorted loads.
	task automatic load_and_merge(input int n_first, input int n_second, input bit narrow);
		int                       left_a;
		int                       left_b;
		logic signed [DATA_W-1:0] val_a;
		logic signed [DATA_W-1:0] val_b;
		logic signed [DATA_W-1:0] v;
		bit                       pick_b;
		left_a = n_first;
		left_b = n_second;
		if (narrow) begin
			val_a = int'($urandom_range(16)) - 8;
			val_b = int'($urandom_range(16)) - 8;
		end else begin
			val_a = $urandom;
			val_b = $urandom;
		end
		while (left_a + left_b > 0) begin
			pick_b = (left_a == 0) || (left_b != 0 && $urandom_range(1) == 1);
			if ($urandom_range(19) == 0)
				v = $urandom;
			else
				v = pick_b ? val_b : val_a;
			send_cmd(pick_b ? FUNC_PUSH_B : FUNC_PUSH_A, v);
			if (pick_b) begin
				val_b = next_ascending(val_b, narrow);
				left_b--;
			end else begin
				val_a = next_ascending(val_a, narrow);
				left_a--;
			end
		end
		send_cmd(FUNC_MERGE, $urandom);
	endtask

	// The unused code and a merge of two empty stores must both stay silent.
	task automatic test_ignored_and_empty();
		sender_idle_pct = 0;
		send_cmd(FUNC_UNUSED, VAL_MAX);
		send_cmd(FUNC_MERGE, VAL_MIN);
		send_cmd(FUNC_MERGE, -1);
	endtask

	// Both extremes on both sides, with ties at the bottom, the top and at
	// zero, so the tie rule and the signed compare are both visible.
	task automatic test_extremes_and_ties();
		send_cmd(FUNC_PUSH_A, VAL_MIN);
		send_cmd(FUNC_PUSH_B, VAL_MIN);
		send_cmd(FUNC_PUSH_B, -1);
		send_cmd(FUNC_PUSH_A, 0);
		send_cmd(FUNC_PUSH_B, 0);
		send_cmd(FUNC_PUSH_A, VAL_MAX);
		send_cmd(FUNC_PUSH_B, VAL_MAX);
		send_cmd(FUNC_MERGE, 0);
	endtask

	// Only one store loaded: the merge just drains that side in order. The
	// sender waits for the first run to finish before loading the other side.
	task automatic test_one_sided();
		send_cmd(FUNC_PUSH_A, -5);
		send_cmd(FUNC_PUSH_A, 7);
		send_cmd(FUNC_MERGE, 0);
		wait_drained();
		send_cmd(FUNC_PUSH_B, 3);
		send_cmd(FUNC_PUSH_B, 3);
		send_cmd(FUNC_MERGE, 0);
	endtask

	// Descending loads still go through the plain head comparison; the unused
	// code in the middle must not disturb the stores.
	task automatic test_unsorted_loads();
		send_cmd(FUNC_PUSH_A, 10);
		send_cmd(FUNC_UNUSED, 1);
		send_cmd(FUNC_PUSH_A, -10);
		send_cmd(FUNC_PUSH_B, 0);
		send_cmd(FUNC_MERGE, 0);
		wait_drained();
	endtask

	// Overfill both stores by two each: the extra pushes are dropped and the
	// merge gives the largest possible run of beats.
	task automatic test_full_stores();
		sender_idle_pct = 0;
		load_and_merge(DEPTH + 2, DEPTH + 2, $urandom_range(1));
		wait_drained();
	endtask

	// Mostly short well-formed runs with random content, some noise in
	// between: unused codes and merges with nothing loaded. Each phase ends
	// with the sender waiting until all beats are back.
	task automatic test_random_traffic(input int idle_pct, input int n_items);
		int goal;
		sender_idle_pct = idle_pct;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			case ($urandom_range(9))
				0: send_cmd(FUNC_UNUSED, $urandom);
				1: load_and_merge(0, 0, 1'b0);
				default: load_and_merge($urandom_range(6), $urandom_range(6), $urandom_range(1));
			endcase
		end
		wait_drained();
	endtask

	// Result checker. The receiver cannot stall, so every edge with res_valid
	// high is one result beat, compared with the oldest prediction.
	always @(posedge clk) begin
		ssm_out_t want;
		if (arst_n && res_valid === 1'b1) begin
			if (merged_beats_q.size() == 0) begin
				$error("result beat with nothing expected: value_res %0d", res.value_res);
				error_count++;
			end else begin
				want = merged_beats_q.pop_front();
				if (res.value_res !== want.value_res) begin
					$error("value_res: expected %0d, got %0d", want.value_res, res.value_res);
					error_count++;
				end
				if (res.from_second !== want.from_second) begin
					$error("from_second: expected %0b, got %0b", want.from_second,
						res.from_second);
					error_count++;
				end
				if (res.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res.last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a missing beat ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_and_empty();
		test_extremes_and_ties();
		test_one_sided();
		test_unsorted_loads();

		// Sender idles rarely at first, then very often, then never.
		test_random_traffic(8, 6);
		test_random_traffic(84, 6);
		test_random_traffic(0, 6);
		test_full_stores();

		wait_drained();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/ssm_pkg.sv
rtl/ssm_ram.sv
rtl/ssm_cmp.sv
rtl/ssm_ctl.sv
rtl/sorted_sequence_merge_top.sv
tb/sv/sorted_sequence_merge_top_tb.sv
